// ===== rtl/sqc_pkg.sv =====
`default_nettype none
package sqc_pkg;

    // Configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] THRESHOLD_RESET = 16'd32768;
    localparam logic [4:0]  RADIUS_RESET    = 5'd9;
    localparam logic [8:0]  WIDTH_RESET     = 9'd256;
    localparam logic [8:0]  HEIGHT_RESET    = 9'd256;

    // Fanout counts that get a flag
    localparam int BRANCH_COUNT = 3;
    localparam int LEAF_COUNT   = 1;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic write_pixel;
        logic accept_query;
        logic rd_centre;
        logic chk_centre;
        logic start_walk;
        logic walk_step;
        logic load_out;
    } sqc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic centre_dark;
        logic radius_zero;
        logic walk_last;
    } sqc_status_t;

endpackage
`default_nettype wire

// ===== rtl/sqc_ram.sv =====
`default_nettype none
module sqc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sqc_ctrl.sv =====
`default_nettype none
module sqc_ctrl import sqc_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire sqc_status_t status,
    output sqc_cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD_C  = 3'd1;
    localparam logic [2:0] ST_CHK_C = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Sequence one query; writes finish at their transfer
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.write_pixel  = in_xfer && (req_type == REQ_WRITE);
                cmd.accept_query = in_xfer && (req_type == REQ_QUERY);
                if (cmd.accept_query)
                begin
                    state_next = ST_RD_C;
                end
            end
            ST_RD_C:
            begin
                cmd.rd_centre = 1'b1;
                state_next    = ST_CHK_C;
            end
            ST_CHK_C:
            begin
                cmd.chk_centre = 1'b1;
                if (status.centre_dark && !status.radius_zero)
                begin
                    cmd.start_walk = 1'b1;
                    state_next     = ST_WALK;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result until its transfer
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A light centre or a zero radius skips the walk
    a_skip_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK_C && !(status.centre_dark && !status.radius_zero))
        |=> state_reg == ST_FIN)
        else $error("walk started without a dark centre");

    // The last contour read drains and then finishes
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && status.walk_last)
        |=> state_reg == ST_DRAIN ##1 state_reg == ST_FIN)
        else $error("walk did not drain after its last read");

    // A new result appears only out of the finish state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside the finish state");

endmodule
`default_nettype wire

// ===== rtl/sqc_dpath.sv =====
`default_nettype none
module sqc_dpath import sqc_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 31,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [7:0]            pos_x,
    input  wire logic [7:0]            pos_y,
    input  wire logic [15:0]           pixel_value,
    input  wire sqc_cmd_t              cmd,
    output sqc_status_t                status,
    output logic [6:0]                 fanout_count,
    output logic                       centre_is_dark,
    output logic                       is_branch,
    output logic                       is_leaf
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int R_W    = $clog2(MAX_RADIUS + 1);
    localparam int T_W    = R_W + 1;
    localparam int CW     = ((R_W > 8) ? R_W : 8) + 2;
    localparam int CNT_RW = $clog2(4 * MAX_RADIUS + 1);
    localparam int CNT_W  = (CNT_RW > 7) ? CNT_RW : 7;

    localparam logic [1:0] SEG_BOTTOM = 2'd0;
    localparam logic [1:0] SEG_RIGHT  = 2'd1;
    localparam logic [1:0] SEG_TOP    = 2'd2;
    localparam logic [1:0] SEG_LEFT   = 2'd3;

    localparam logic [1:0] SHADE_OUT   = 2'd0;
    localparam logic [1:0] SHADE_LIGHT = 2'd1;
    localparam logic [1:0] SHADE_DARK  = 2'd2;

    logic [15:0]           thr_reg;
    logic [4:0]            radius_reg;
    logic [8:0]            width_reg;
    logic [8:0]            height_reg;

    logic [R_W-1:0]        eff_r;
    logic [8:0]            eff_w;
    logic [8:0]            eff_h;
    logic signed [CW-1:0]  r_s;
    logic [T_W-1:0]        side_m1;

    logic signed [CW-1:0]  cx_reg;
    logic signed [CW-1:0]  cy_reg;
    logic signed [CW-1:0]  px_reg;
    logic signed [CW-1:0]  py_reg;
    logic [1:0]            seg_reg;
    logic [T_W-1:0]        t_reg;

    logic signed [CW-1:0]  rx;
    logic signed [CW-1:0]  ry;
    logic                  rd_in;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [PIXEL_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [PIXEL_BITS-1:0] ram_rdata;

    logic                  p1_valid_reg;
    logic                  p1_first_reg;
    logic                  p1_last_reg;
    logic                  p1_in_reg;

    logic                  cur_dark;
    logic [1:0]            cur_shade;
    logic [1:0]            prev_reg;
    logic [1:0]            first_reg;
    logic                  inc_step;
    logic                  inc_close;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  dark_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THRESHOLD_RESET;
            radius_reg <= RADIUS_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg    <= cfg_wdata;
                REG_RADIUS:    radius_reg <= cfg_wdata[4:0];
                REG_WIDTH:     width_reg  <= cfg_wdata[8:0];
                REG_HEIGHT:    height_reg <= cfg_wdata[8:0];
                default:       ;
            endcase
        end
    end

    // Saturate radius and image size
    assign eff_r   = (32'(radius_reg) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : R_W'(radius_reg);
    assign eff_w   = (32'(width_reg) > MAX_WIDTH) ? 9'(MAX_WIDTH) : width_reg;
    assign eff_h   = (32'(height_reg) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : height_reg;
    assign r_s     = $signed(CW'(eff_r));
    assign side_m1 = {eff_r, 1'b0} - T_W'(1);

    // Pixel writes outside the store are dropped
    assign ram_we    = cmd.write_pixel && (32'(pos_x) < MAX_WIDTH)
                       && (32'(pos_y) < MAX_HEIGHT);
    assign ram_waddr = AW'(32'(pos_y) * MAX_WIDTH + 32'(pos_x));
    assign ram_wdata = pixel_value[PIXEL_BITS-1:0];

    // Select the read coordinate and test it against the image
    assign rx    = cmd.rd_centre ? cx_reg : px_reg;
    assign ry    = cmd.rd_centre ? cy_reg : py_reg;
    assign rd_in = (rx >= 0) && (rx < $signed({1'b0, eff_w}))
                   && (ry >= 0) && (ry < $signed({1'b0, eff_h}));

    assign ram_re    = (cmd.rd_centre || cmd.walk_step) && rd_in;
    assign ram_raddr = AW'(32'(ry[CW-2:0]) * MAX_WIDTH + 32'(rx[CW-2:0]));

    sqc_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Capture the query centre
    always_ff @(posedge clk)
    begin
        if (cmd.accept_query)
        begin
            cx_reg <= $signed(CW'(pos_x));
            cy_reg <= $signed(CW'(pos_y));
        end
    end

    // Step counter and position along the contour
    always_ff @(posedge clk)
    begin
        if (cmd.start_walk)
        begin
            px_reg  <= cx_reg - r_s;
            py_reg  <= cy_reg - r_s;
            seg_reg <= SEG_BOTTOM;
            t_reg   <= '0;
        end
        else if (cmd.walk_step)
        begin
            case (seg_reg)
                SEG_BOTTOM: px_reg <= px_reg + CW'(1);
                SEG_RIGHT:  py_reg <= py_reg + CW'(1);
                SEG_TOP:    px_reg <= px_reg - CW'(1);
                SEG_LEFT:   py_reg <= py_reg - CW'(1);
                default:    ;
            endcase
            if (t_reg == side_m1)
            begin
                t_reg   <= '0;
                seg_reg <= seg_reg + 2'd1;
            end
            else
            begin
                t_reg <= t_reg + T_W'(1);
            end
        end
    end

    assign status.walk_last   = (seg_reg == SEG_LEFT) && (t_reg == side_m1);
    assign status.radius_zero = (eff_r == '0);

    // Track each read through the memory stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.walk_step;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_first_reg <= (seg_reg == SEG_BOTTOM) && (t_reg == '0);
        p1_last_reg  <= status.walk_last;
        p1_in_reg    <= rd_in;
    end

    // Classify the pixel that came back
    assign cur_dark           = 16'(ram_rdata) < thr_reg;
    assign status.centre_dark = p1_in_reg && cur_dark;
    assign cur_shade          = !p1_in_reg ? SHADE_OUT : (cur_dark ? SHADE_DARK : SHADE_LIGHT);

    // Count light-to-dark steps; the last pixel also closes the loop
    assign inc_step   = !p1_first_reg && (prev_reg == SHADE_LIGHT) && (cur_shade == SHADE_DARK);
    assign inc_close  = p1_last_reg && (cur_shade == SHADE_LIGHT) && (first_reg == SHADE_DARK);
    assign count_next = count_reg + CNT_W'(inc_step) + CNT_W'(inc_close);

    always_ff @(posedge clk)
    begin
        if (cmd.accept_query)
        begin
            count_reg <= '0;
        end
        else if (p1_valid_reg)
        begin
            count_reg <= count_next;
            prev_reg  <= cur_shade;
            if (p1_first_reg)
            begin
                first_reg <= cur_shade;
            end
        end
    end

    // Latch the centre test
    always_ff @(posedge clk)
    begin
        if (cmd.chk_centre)
        begin
            dark_reg <= status.centre_dark;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            fanout_count   <= count_reg[6:0];
            centre_is_dark <= dark_reg;
            is_branch      <= dark_reg && (count_reg == CNT_W'(BRANCH_COUNT));
            is_leaf        <= dark_reg && (count_reg == CNT_W'(LEAF_COUNT));
        end
    end

endmodule
`default_nettype wire

// ===== rtl/square_contour_fanout_count_core.sv =====
`default_nettype none
// Pixel write: completes at its transfer; the block stays ready for another request.
// Query: the centre pixel is read and tested; a dark centre with a nonzero
// effective radius starts the contour walk, which visits one contour pixel per
// cycle, reading those inside the image; queries are handled one at a time.
// Reset (rst_n, asynchronous, active low) empties the result register and sets
// the registers to their defaults; the pixel memory is not cleared.
module square_contour_fanout_count_core import sqc_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 31,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [REG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  req_type,
    input  wire logic [7:0]            pos_x,
    input  wire logic [7:0]            pos_y,
    input  wire logic [15:0]           pixel_value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [6:0]                 fanout_count,
    output logic                       centre_is_dark,
    output logic                       is_branch,
    output logic                       is_leaf
);

    sqc_cmd_t    cmd;
    sqc_status_t status;

    sqc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sqc_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pixel_value    (pixel_value),
        .cmd            (cmd),
        .status         (status),
        .fanout_count   (fanout_count),
        .centre_is_dark (centre_is_dark),
        .is_branch      (is_branch),
        .is_leaf        (is_leaf)
    );

endmodule
`default_nettype wire
